FILE: rtl/core/sdtc_pkg.sv
// ----------------------------------------------------------------------------
// sdtc_pkg: shared types for the single/double tap classifier
// Event codes, action codes, register indexes and the classifier state word.
// ----------------------------------------------------------------------------
`default_nettype none

package sdtc_pkg;

   localparam int unsigned TIME_W     = 32;
   localparam int unsigned CFG_W      = 16;
   localparam int unsigned CSR_ADDR_W = 8;

   typedef enum logic [1:0] {
      FUNC_PRESS   = 2'd0,
      FUNC_RELEASE = 2'd1,
      FUNC_TICK    = 2'd2,
      FUNC_CANCEL  = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      ACT_NONE   = 2'd0,
      ACT_DOUBLE = 2'd1,
      ACT_SINGLE = 2'd2
   } action_type;

   localparam logic [CSR_ADDR_W-1:0] CSR_DOUBLE_WINDOW = CSR_ADDR_W'(0);
   localparam logic [CSR_ADDR_W-1:0] CSR_TAP_MAX       = CSR_ADDR_W'(1);

   localparam logic [CFG_W-1:0] DOUBLE_WINDOW_RESET = CFG_W'(400);
   localparam logic [CFG_W-1:0] TAP_MAX_RESET       = CFG_W'(300);

   typedef struct packed {
      logic              single_pending;
      logic [TIME_W-1:0] pending_since;
      logic              tap_armed;
      logic [TIME_W-1:0] first_press_time;
      logic              button_held;
      logic [TIME_W-1:0] press_time;
      logic              press_consumed;
   } state_type;

endpackage

`default_nettype wire

FILE: rtl/core/sdtc_eval.sv
// ----------------------------------------------------------------------------
// sdtc_eval: next-state and action logic for one button event
// Wrap-safe elapsed times against the window and tap limit, one event per call.
// ----------------------------------------------------------------------------
`default_nettype none

module sdtc_eval (
   input  sdtc_pkg::state_type                  cur_state,
   input  sdtc_pkg::func_type                   func,
   input  logic [sdtc_pkg::TIME_W-1:0]          now_ms,
   input  logic [sdtc_pkg::CFG_W-1:0]           double_window_ms,
   input  logic [sdtc_pkg::CFG_W-1:0]           tap_max_ms,
   output sdtc_pkg::state_type                  nxt_state,
   output sdtc_pkg::action_type                 action
);

   logic [sdtc_pkg::TIME_W-1:0] since_first;
   logic [sdtc_pkg::TIME_W-1:0] since_press;
   logic [sdtc_pkg::TIME_W-1:0] since_pending;
   logic [sdtc_pkg::TIME_W-1:0] window_ext;
   logic [sdtc_pkg::TIME_W-1:0] tap_max_ext;

   assign since_first   = now_ms - cur_state.first_press_time;
   assign since_press   = now_ms - cur_state.press_time;
   assign since_pending = now_ms - cur_state.pending_since;
   assign window_ext    = sdtc_pkg::TIME_W'(double_window_ms);
   assign tap_max_ext   = sdtc_pkg::TIME_W'(tap_max_ms);

   always_comb begin
      nxt_state = cur_state;
      action    = sdtc_pkg::ACT_NONE;
      case (func)
         sdtc_pkg::FUNC_PRESS: begin
            nxt_state.button_held    = 1'b1;
            nxt_state.press_time     = now_ms;
            nxt_state.press_consumed = 1'b0;
            if (cur_state.tap_armed && (since_first <= window_ext)) begin
               nxt_state.single_pending = 1'b0;
               nxt_state.tap_armed      = 1'b0;
               nxt_state.press_consumed = 1'b1;
               action                   = sdtc_pkg::ACT_DOUBLE;
            end else begin
               nxt_state.first_press_time = now_ms;
               nxt_state.tap_armed        = 1'b1;
            end
         end
         sdtc_pkg::FUNC_RELEASE: begin
            nxt_state.button_held    = 1'b0;
            nxt_state.press_consumed = 1'b0;
            if (cur_state.button_held && !cur_state.press_consumed) begin
               if (since_press >= tap_max_ext) begin
                  nxt_state.single_pending = 1'b0;
                  nxt_state.tap_armed      = 1'b0;
               end else begin
                  nxt_state.single_pending = 1'b1;
                  nxt_state.pending_since  = cur_state.press_time;
               end
            end
         end
         sdtc_pkg::FUNC_TICK: begin
            if (cur_state.single_pending && (since_pending > window_ext)) begin
               nxt_state.single_pending = 1'b0;
               nxt_state.tap_armed      = 1'b0;
               action                   = sdtc_pkg::ACT_SINGLE;
            end
         end
         default: begin
            nxt_state = '0;
         end
      endcase
   end

endmodule

`default_nettype wire

FILE: rtl/core/single_double_tap_classifier_core.sv
// ----------------------------------------------------------------------------
// single_double_tap_classifier_core: button single/double tap classifier
// Takes press/release/tick/cancel words and returns one action word each.
//
//   port group | direction | handshake         | payload
//   req_       | in        | valid / stall     | func, now_ms
//   rsp_       | out       | valid / stall     | action
//   csr_       | in        | valid / ready     | index, wdata
//
// One word per cycle while rsp_stall is low, via event and result registers.
// The event is registered, evaluated against the state registers, and the
// action is registered while the state updates in the same edge.
// Reset clears state, pipeline valids and restores the register defaults.
// A stalled result holds the event register; req_stall rises only then.
// ----------------------------------------------------------------------------
`default_nettype none

module single_double_tap_classifier_core (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [1:0]                        req_func,
   input  logic [sdtc_pkg::TIME_W-1:0]       req_now_ms,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [1:0]                        rsp_action,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [sdtc_pkg::CSR_ADDR_W-1:0]   csr_index,
   input  logic [sdtc_pkg::CFG_W-1:0]        csr_wdata
);

   logic                          st1_valid_ff;
   sdtc_pkg::func_type            st1_func_ff;
   logic [sdtc_pkg::TIME_W-1:0]   st1_now_ms_ff;
   logic                          out_valid_ff;
   sdtc_pkg::action_type          out_action_ff;
   sdtc_pkg::state_type           state_ff;
   sdtc_pkg::state_type           state_in;
   sdtc_pkg::action_type          action_in;
   logic [sdtc_pkg::CFG_W-1:0]    window_ff;
   logic [sdtc_pkg::CFG_W-1:0]    tap_max_ff;
   logic                          advance;
   logic                          req_take;
   logic                          csr_take;

   assign advance   = st1_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = st1_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;
   assign csr_ready = 1'b1;
   assign csr_take  = csr_valid && csr_ready;

   assign rsp_valid  = out_valid_ff;
   assign rsp_action = out_action_ff;

   sdtc_eval u_eval (
      .cur_state        (state_ff),
      .func             (st1_func_ff),
      .now_ms           (st1_now_ms_ff),
      .double_window_ms (window_ff),
      .tap_max_ms       (tap_max_ff),
      .nxt_state        (state_in),
      .action           (action_in)
   );

   // event register
   always_ff @(posedge clock) begin
      if (reset) begin
         st1_valid_ff <= 1'b0;
      end else if (req_take) begin
         st1_valid_ff <= 1'b1;
      end else if (advance) begin
         st1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         st1_func_ff   <= sdtc_pkg::func_type'(req_func);
         st1_now_ms_ff <= req_now_ms;
      end
   end

   // result register and classifier state
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         state_ff     <= '0;
      end else begin
         if (advance) begin
            out_valid_ff <= 1'b1;
            state_ff     <= state_in;
         end else if (!rsp_stall) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_action_ff <= action_in;
      end
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff  <= sdtc_pkg::DOUBLE_WINDOW_RESET;
         tap_max_ff <= sdtc_pkg::TAP_MAX_RESET;
      end else if (csr_take) begin
         case (csr_index)
            sdtc_pkg::CSR_DOUBLE_WINDOW: window_ff  <= csr_wdata;
            sdtc_pkg::CSR_TAP_MAX:       tap_max_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   a_double_clears: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_action_ff == sdtc_pkg::ACT_DOUBLE)
         |-> (!state_ff.single_pending && !state_ff.tap_armed))
      else $error("double tap left a tap armed or pending");

   a_single_clears: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_action_ff == sdtc_pkg::ACT_SINGLE)
         |-> (!state_ff.single_pending && !state_ff.tap_armed))
      else $error("single tap left a tap armed or pending");

   a_consumed_held: assert property (@(posedge clock) disable iff (reset)
      state_ff.press_consumed |-> state_ff.button_held)
      else $error("consumed press without held button");

   a_stall_needs_word: assert property (@(posedge clock) disable iff (reset)
      !st1_valid_ff |-> !req_stall)
      else $error("input stalled with empty event register");

   a_window_write: assert property (@(posedge clock) disable iff (reset)
      (csr_take && csr_index == sdtc_pkg::CSR_DOUBLE_WINDOW)
         |=> (window_ff == $past(csr_wdata)))
      else $error("double window register write lost");

endmodule

`default_nettype wire

FILE: dv/tb_single_double_tap_classifier_core.sv
// ----------------------------------------------------------------------------
// tb_single_double_tap_classifier_core: tap classifier testbench
// Drives press/release/tick/cancel words into the core and predicts each
// action word with an in-bench tap tracker. Every response word is compared
// in order against the tracker's queue. The run covers directed gestures,
// wrap-around timestamps, several window/tap-limit settings, random idle and
// stall on both channels and a long response hold-off that backs up the core.
// ----------------------------------------------------------------------------
module tb_single_double_tap_classifier_core;
   import sdtc_pkg::*;

   localparam int unsigned CYCLE_LIMIT     = 400000;
   localparam int unsigned DRAIN_CYCLES    = 6;
   localparam int unsigned HOLD_OFF_CYCLES = 300;
   localparam logic [CSR_ADDR_W-1:0] CSR_PAST_LIST = CSR_TAP_MAX + 1'b1;
   localparam logic [CSR_ADDR_W-1:0] CSR_TOP_INDEX = '1;

   class tap_scoreboard;
      logic [CFG_W-1:0]  window_ms;
      logic [CFG_W-1:0]  tap_limit_ms;
      bit                single_pending;
      bit                tap_armed;
      bit                button_held;
      bit                press_consumed;
      logic [TIME_W-1:0] pending_since;
      logic [TIME_W-1:0] first_press_time;
      logic [TIME_W-1:0] press_time;
      action_type        actions_due[$];
      int unsigned       errors;

      function new();
         window_ms    = DOUBLE_WINDOW_RESET;
         tap_limit_ms = TAP_MAX_RESET;
         errors       = 0;
         clear_taps();
      endfunction

      function void clear_taps();
         single_pending   = 1'b0;
         tap_armed        = 1'b0;
         button_held      = 1'b0;
         press_consumed   = 1'b0;
         pending_since    = '0;
         first_press_time = '0;
         press_time       = '0;
      endfunction

      function void write_reg(logic [CSR_ADDR_W-1:0] idx, logic [CFG_W-1:0] data);
         if (idx == CSR_DOUBLE_WINDOW) window_ms = data;
         else if (idx == CSR_TAP_MAX) tap_limit_ms = data;
      endfunction

      function void classify_event(func_type f, logic [TIME_W-1:0] now_ms);
         action_type        act;
         logic [TIME_W-1:0] since_first;
         logic [TIME_W-1:0] since_press;
         logic [TIME_W-1:0] since_pending;
         act           = ACT_NONE;
         since_first   = now_ms - first_press_time;
         since_press   = now_ms - press_time;
         since_pending = now_ms - pending_since;
         case (f)
            FUNC_PRESS: begin
               button_held    = 1'b1;
               press_time     = now_ms;
               press_consumed = 1'b0;
               if (tap_armed && since_first <= {16'd0, window_ms}) begin
                  single_pending = 1'b0;
                  tap_armed      = 1'b0;
                  press_consumed = 1'b1;
                  act            = ACT_DOUBLE;
               end else begin
                  first_press_time = now_ms;
                  tap_armed        = 1'b1;
               end
            end
            FUNC_RELEASE: begin
               if (button_held && !press_consumed) begin
                  if (since_press >= {16'd0, tap_limit_ms}) begin
                     single_pending = 1'b0;
                     tap_armed      = 1'b0;
                  end else begin
                     single_pending = 1'b1;
                     pending_since  = press_time;
                  end
               end
               button_held    = 1'b0;
               press_consumed = 1'b0;
            end
            FUNC_TICK: begin
               if (single_pending && since_pending > {16'd0, window_ms}) begin
                  single_pending = 1'b0;
                  tap_armed      = 1'b0;
                  act            = ACT_SINGLE;
               end
            end
            default: clear_taps();
         endcase
         actions_due.push_back(act);
      endfunction

      function void check_action(logic [1:0] act);
         action_type want;
         if (actions_due.size() == 0) begin
            $error("action: expected none, got %0d", act);
            errors++;
         end else begin
            want = actions_due.pop_front();
            if (act !== want) begin
               $error("action: expected %0d, got %0d", want, act);
               errors++;
            end
         end
      endfunction

      function int unsigned outstanding();
         return actions_due.size();
      endfunction
   endclass

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   logic [1:0]            req_func;
   logic [TIME_W-1:0]     req_now_ms;
   logic                  rsp_valid;
   logic                  rsp_stall;
   logic [1:0]            rsp_action;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [CSR_ADDR_W-1:0] csr_index;
   logic [CFG_W-1:0]      csr_wdata;

   tap_scoreboard     sb = new();
   int unsigned       snd_idle_pct;
   int unsigned       rcv_idle_pct;
   int unsigned       hold_off_requests;
   int unsigned       hold_off_served;
   int unsigned       hold_left;
   int unsigned       words_sent;
   int unsigned       cycle_count;
   logic [TIME_W-1:0] t_base;

   single_double_tap_classifier_core u_top (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_func   (req_func),
      .req_now_ms (req_now_ms),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_action (rsp_action),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
   end

   always #4 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb_single_double_tap_classifier_core NOT OK");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid === 1'b1 && !rsp_stall) sb.check_action(rsp_action);
         if (req_valid && req_stall === 1'b0) sb.classify_event(func_type'(req_func), req_now_ms);
         if (csr_valid && csr_ready === 1'b1) sb.write_reg(csr_index, csr_wdata);
      end
   end

   always @(posedge clock) begin
      if (hold_off_requests != hold_off_served) begin
         hold_off_served = hold_off_requests;
         hold_left       = HOLD_OFF_CYCLES;
      end
      if (hold_left != 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= (!reset && $urandom_range(0, 99) < rcv_idle_pct);
      end
   end

   function automatic logic [TIME_W-1:0] near_edge(logic [TIME_W-1:0] limit);
      case ($urandom_range(0, 5))
         0:       return '0;
         1:       return (limit == 0) ? limit : limit - 1;
         2:       return limit;
         3:       return limit + 1;
         4:       return $urandom_range(0, limit);
         default: return limit + $urandom_range(1, 1000);
      endcase
   endfunction

   task automatic send_word(input func_type f, input logic [TIME_W-1:0] t);
      int unsigned gap;
      gap = 0;
      while (gap < 30 && $urandom_range(0, 99) < snd_idle_pct) gap++;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_func   <= f;
      req_now_ms <= t;
      do @(posedge clock); while (req_stall !== 1'b0);
      words_sent++;
   endtask

   task automatic write_csr(input logic [CSR_ADDR_W-1:0] idx, input logic [CFG_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (csr_ready !== 1'b1);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(negedge clock);
      while (sb.outstanding() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic run_directed();
      send_word(FUNC_RELEASE, 32'd0);
      send_word(FUNC_TICK, 32'd1000);
      send_word(FUNC_PRESS, 32'd1000);
      send_word(FUNC_RELEASE, 32'd1100);
      send_word(FUNC_TICK, 32'd1400);
      send_word(FUNC_TICK, 32'd1401);
      send_word(FUNC_PRESS, 32'd2000);
      send_word(FUNC_RELEASE, 32'd2299);
      send_word(FUNC_PRESS, 32'd2400);
      send_word(FUNC_RELEASE, 32'd2450);
      send_word(FUNC_TICK, 32'd5000);
      send_word(FUNC_PRESS, 32'd3000);
      send_word(FUNC_RELEASE, 32'd3300);
      send_word(FUNC_TICK, 32'd9000);
      send_word(FUNC_PRESS, 32'hFFFF_FF00);
      send_word(FUNC_RELEASE, 32'hFFFF_FF10);
      send_word(FUNC_PRESS, 32'h0000_0090);
      send_word(FUNC_PRESS, 32'd20000);
      send_word(FUNC_PRESS, 32'd20401);
      send_word(FUNC_RELEASE, 32'd20500);
      send_word(FUNC_TICK, 32'd20802);
      send_word(FUNC_PRESS, 32'd30000);
      send_word(FUNC_CANCEL, 32'd30020);
      send_word(FUNC_PRESS, 32'd30100);
      send_word(FUNC_PRESS, 32'hFFFF_FFFF);
   endtask

   task automatic run_gestures(input int unsigned count);
      int unsigned       stop_at;
      logic [TIME_W-1:0] t0;
      logic [TIME_W-1:0] win;
      logic [TIME_W-1:0] lim;
      logic [TIME_W-1:0] d;
      stop_at = words_sent + count;
      while (words_sent < stop_at) begin
         win = {16'd0, sb.window_ms};
         lim = {16'd0, sb.tap_limit_ms};
         case ($urandom_range(0, 7))
            0:       t_base = $urandom;
            1:       t_base = 32'hFFFF_FFFF - $urandom_range(0, win);
            default: t_base = t_base + win + lim + $urandom_range(1, 2000);
         endcase
         t0 = t_base;
         case ($urandom_range(0, 9))
            0, 1, 2, 3: begin
               send_word(FUNC_PRESS, t0);
               send_word(FUNC_RELEASE, t0 + near_edge(lim));
               send_word(FUNC_TICK, t0 + near_edge(win));
               send_word(FUNC_TICK, t0 + win + 1 + $urandom_range(0, 3));
            end
            4, 5, 6: begin
               d = near_edge(win);
               send_word(FUNC_PRESS, t0);
               send_word(FUNC_RELEASE, t0 + near_edge(lim));
               send_word(FUNC_PRESS, t0 + d);
               send_word(FUNC_RELEASE, t0 + d + near_edge(lim));
               if ($urandom_range(0, 1)) send_word(FUNC_TICK, t0 + d + near_edge(win));
            end
            7: begin
               d = near_edge(win);
               send_word(FUNC_PRESS, t0);
               send_word(FUNC_PRESS, t0 + d);
               send_word(FUNC_RELEASE, t0 + d + near_edge(lim));
               send_word(FUNC_RELEASE, t0 + d + near_edge(lim));
               send_word(FUNC_TICK, t0 + d + near_edge(win));
            end
            8: begin
               send_word(FUNC_PRESS, t0);
               send_word(FUNC_RELEASE, t0 + near_edge(lim));
               send_word(FUNC_CANCEL, t0 + near_edge(win));
               send_word(FUNC_TICK, t0 + win + 1);
            end
            default: begin
               repeat ($urandom_range(1, 4))
                  send_word(func_type'($urandom_range(0, 3)),
                            $urandom_range(0, 1) ? $urandom : t0 + near_edge(win));
            end
         endcase
      end
   endtask

   initial begin
      reset             = 1'b1;
      req_valid         = 1'b0;
      req_func          = FUNC_PRESS;
      req_now_ms        = '0;
      rsp_stall         = 1'b0;
      csr_valid         = 1'b0;
      csr_index         = CSR_DOUBLE_WINDOW;
      csr_wdata         = '0;
      snd_idle_pct      = 38;
      rcv_idle_pct      = 64;
      hold_off_requests = 0;
      hold_off_served   = 0;
      hold_left         = 0;
      words_sent        = 0;
      cycle_count       = 0;
      t_base            = 32'd100000;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      run_directed();
      run_gestures(60);
      wait_drained();

      write_csr(CSR_DOUBLE_WINDOW, 16'd0);
      write_csr(CSR_TAP_MAX, 16'd0);
      run_gestures(70);
      wait_drained();

      snd_idle_pct = 64;
      rcv_idle_pct = 38;
      write_csr(CSR_DOUBLE_WINDOW, 16'hFFFF);
      write_csr(CSR_TAP_MAX, 16'hFFFF);
      run_gestures(70);
      wait_drained();

      write_csr(CSR_PAST_LIST, 16'($urandom));
      write_csr(CSR_TOP_INDEX, 16'($urandom));
      write_csr(CSR_DOUBLE_WINDOW, 16'($urandom));
      write_csr(CSR_TAP_MAX, 16'($urandom));
      run_gestures(70);
      wait_drained();

      snd_idle_pct = 0;
      rcv_idle_pct = 0;
      write_csr(CSR_DOUBLE_WINDOW, DOUBLE_WINDOW_RESET);
      write_csr(CSR_TAP_MAX, TAP_MAX_RESET);
      run_gestures(40);
      hold_off_requests++;
      run_gestures(40);
      wait_drained();

      write_csr(CSR_DOUBLE_WINDOW, 16'd25);
      write_csr(CSR_TAP_MAX, 16'd12);
      run_gestures(40);
      wait_drained();

      if (sb.errors == 0 && sb.outstanding() == 0)
         $display("tb_single_double_tap_classifier_core OK");
      else
         $display("tb_single_double_tap_classifier_core NOT OK");
      $finish;
   end
endmodule
